[rtl/core/bffg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffg_pkg
// Shared types and codes for the box first-fit grouper: operation codes,
// register indexes, the placement kind and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bffg_pkg;

  // Operation codes carried by the input item.
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_LIMIT = 1'b1;

  // Register widths and reset values.
  localparam int unsigned MARGIN_W = 23;
  localparam int unsigned LIMIT_W = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd24320;

  // Input coordinate and output index widths.
  localparam int unsigned POS_W = 24;
  localparam int unsigned GIDX_W = 4;

  // How a finished cluster is placed.
  typedef enum logic [1:0] {
    KIND_FIT,
    KIND_NEW,
    KIND_FULL
  } bffg_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       point_upd;  // fold the accepted point into the cluster box
    logic       clear_all;  // empty the group table, drop the cluster
    logic       pad;        // latch the padded cluster box, reset cluster box
    logic       idx_clr;    // restart the group scan
    logic       idx_inc;    // step to the next group
    logic       rd;         // read the group row at the scan index
    logic       merge;      // latch the merged box of cluster and group
    logic       commit;     // apply the placement and load the result
    bffg_kind_e kind;
  } bffg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no stored groups
    logic full;      // every group slot in use
    logic last;      // scan index is at the last stored group
    logic fit;       // merged box stays within the extent limit
    logic out_busy;  // result register holds an untaken result
  } bffg_status_t;

endpackage

[rtl/core/box_first_fit_grouper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_first_fit_grouper_top
// Gathers point clusters into bounding boxes, pads them and places each
// closed cluster first-fit into a table of group boxes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  in      | input     | in_valid_i / in_stall_o | operation, pos_x/y/z, last_of_cluster
//  out     | output    | out_valid_o/out_stall_i | group_index, opened_group, table_full
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A point that does not close a cluster, and a clear, are taken without leaving
// the idle state. A closing point goes on through padding, then a read, merge
// and extent test for each scanned group (at most every stored group), and
// then the commit.
// The commit waits while the result register holds an untaken result.
// Reset clears the group count and the cluster box; the group table is not
// cleared.
module box_first_fit_grouper_top #(
  parameter int MAX_GROUPS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bffg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bffg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic signed [bffg_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [bffg_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [bffg_pkg::POS_W-1:0] pos_z_i,
  input  logic                              last_of_cluster_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bffg_pkg::GIDX_W-1:0]       group_index_o,
  output logic                              opened_group_o,
  output logic                              table_full_o
);
  import bffg_pkg::*;

  bffg_cmd_t    cmd;
  bffg_status_t status;

  bffg_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .last_of_cluster_i (last_of_cluster_i),
    .status_i          (status),
    .cmd_o             (cmd)
  );

  bffg_datapath #(
    .MAX_GROUPS (MAX_GROUPS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .group_index_o  (group_index_o),
    .opened_group_o (opened_group_o),
    .table_full_o   (table_full_o)
  );

endmodule

[rtl/core/bffg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffg_ctrl
// Sequencer of the grouper: accepts items, runs the first-fit scan over the
// stored groups and commits the placement once the result register is free.
// ----------------------------------------------------------------------------
module bffg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic                  last_of_cluster_i,
  input  bffg_pkg::bffg_status_t status_i,
  output bffg_pkg::bffg_cmd_t    cmd_o
);
  import bffg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_READ,
    ST_MERGE,
    ST_TEST,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  bffg_kind_e kind_q, kind_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    cmd_o = '0;
    cmd_o.kind = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_CLEAR) begin
            cmd_o.clear_all = 1'b1;
          end else begin
            cmd_o.point_upd = 1'b1;
            if (last_of_cluster_i) begin
              state_d = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        cmd_o.idx_clr = 1'b1;
        if (status_i.empty) begin
          kind_d = KIND_NEW;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (status_i.fit) begin
          kind_d = KIND_FIT;
          state_d = ST_EMIT;
        end else if (status_i.last) begin
          kind_d = status_i.full ? KIND_FULL : KIND_NEW;
          state_d = ST_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q <= KIND_FIT;
    end else begin
      state_q <= state_d;
      kind_q <= kind_d;
    end
  end

endmodule

[rtl/core/bffg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffg_datapath
// Cluster box, padding, group table memory, merge and extent test, group
// count, configuration registers and the result register.
// ----------------------------------------------------------------------------
module bffg_datapath #(
  parameter int MAX_GROUPS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bffg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bffg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [bffg_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [bffg_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [bffg_pkg::POS_W-1:0]  pos_z_i,
  input  bffg_pkg::bffg_cmd_t                cmd_i,
  output bffg_pkg::bffg_status_t             status_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bffg_pkg::GIDX_W-1:0]        group_index_o,
  output logic                               opened_group_o,
  output logic                               table_full_o
);
  import bffg_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CNT_W = $clog2(MAX_GROUPS + 1);
  // Wide enough for a coordinate plus or minus the margin, and for an extent.
  localparam int EW = ((CW > int'(POS_W)) ? CW : int'(POS_W)) + 2;
  localparam logic signed [EW-1:0] CTOP = $signed({{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [EW-1:0] CBOT = ~CTOP;

  typedef logic [2:0][CW-1:0] box_t;

  // Saturate a wide value to the coordinate range.
  function automatic logic [CW-1:0] sat(input logic signed [EW-1:0] v);
    logic [CW-1:0] r;
    if (v > CTOP) begin
      r = CTOP[CW-1:0];
    end else if (v < CBOT) begin
      r = CBOT[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [EW-1:0] sext(input logic [CW-1:0] c);
    return $signed({{(EW-CW){c[CW-1]}}, c});
  endfunction

  logic [MARGIN_W-1:0] margin_q;
  logic [LIMIT_W-1:0]  limit_q;
  box_t                cbox_lo_q, cbox_hi_q;
  box_t                cbox_lo_d, cbox_hi_d;
  box_t                pad_lo_q, pad_hi_q, pad_lo_d, pad_hi_d;
  box_t                mrg_lo_q, mrg_hi_q, mrg_lo_d, mrg_hi_d;
  logic [1:0][2:0][CW-1:0] mem_q [MAX_GROUPS];
  logic [1:0][2:0][CW-1:0] rd_q;
  logic [1:0][2:0][CW-1:0] wr_row;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_en;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    idx_q;
  logic                out_valid_q;
  logic [GIDX_W-1:0]   out_index_q;
  logic                out_opened_q, out_full_q;
  logic [2:0][CW-1:0]  pnt;
  logic [2:0]          axis_ok;
  logic [IDX_W+GIDX_W-1:0] idx_wide, cnt_wide;

  // Point update of the cluster box and padding of the closed cluster.
  always_comb begin
    pnt[0] = sat($signed({{(EW-POS_W){pos_x_i[POS_W-1]}}, pos_x_i}));
    pnt[1] = sat($signed({{(EW-POS_W){pos_y_i[POS_W-1]}}, pos_y_i}));
    pnt[2] = sat($signed({{(EW-POS_W){pos_z_i[POS_W-1]}}, pos_z_i}));
    for (int a = 0; a < 3; a++) begin
      cbox_lo_d[a] = ($signed(pnt[a]) < $signed(cbox_lo_q[a])) ? pnt[a] : cbox_lo_q[a];
      cbox_hi_d[a] = ($signed(pnt[a]) > $signed(cbox_hi_q[a])) ? pnt[a] : cbox_hi_q[a];
      pad_lo_d[a] = sat(sext(cbox_lo_q[a]) - $signed({{(EW-MARGIN_W){1'b0}}, margin_q}));
      pad_hi_d[a] = sat(sext(cbox_hi_q[a]) + $signed({{(EW-MARGIN_W){1'b0}}, margin_q}));
    end
  end

  // Merge of the padded cluster box with the group row just read.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mrg_lo_d[a] = ($signed(pad_lo_q[a]) < $signed(rd_q[0][a])) ? pad_lo_q[a] : rd_q[0][a];
      mrg_hi_d[a] = ($signed(pad_hi_q[a]) > $signed(rd_q[1][a])) ? pad_hi_q[a] : rd_q[1][a];
    end
  end

  // The widest axis fits exactly when every axis fits.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_ok[a] = (sext(mrg_hi_q[a]) - sext(mrg_lo_q[a]))
                   <= $signed({{(EW-LIMIT_W){1'b0}}, limit_q});
    end
  end

  // Group table write port.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_row = {pad_hi_q, pad_lo_q};
    if (cmd_i.commit) begin
      case (cmd_i.kind)
        KIND_FIT: begin
          wr_en = 1'b1;
          wr_addr = idx_q;
          wr_row = {mrg_hi_q, mrg_lo_q};
        end
        KIND_NEW: begin
          wr_en = 1'b1;
          wr_addr = count_q[IDX_W-1:0];
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign idx_wide = {{GIDX_W{1'b0}}, idx_q};
  assign cnt_wide = {{GIDX_W{1'b0}}, count_q[IDX_W-1:0]};

  // Control state, cluster box and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
      limit_q <= LIMIT_RESET;
      count_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cbox_lo_q[a] <= CTOP[CW-1:0];
        cbox_hi_q[a] <= CBOT[CW-1:0];
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOX_MARGIN:   margin_q <= cfg_data_i[MARGIN_W-1:0];
          REG_EXTENT_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.clear_all || cmd_i.pad) begin
        for (int a = 0; a < 3; a++) begin
          cbox_lo_q[a] <= CTOP[CW-1:0];
          cbox_hi_q[a] <= CBOT[CW-1:0];
        end
      end else if (cmd_i.point_upd) begin
        cbox_lo_q <= cbox_lo_d;
        cbox_hi_q <= cbox_hi_d;
      end
      if (cmd_i.clear_all) begin
        count_q <= '0;
      end else if (cmd_i.commit && (cmd_i.kind == KIND_NEW)) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and the group table memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pad) begin
      pad_lo_q <= pad_lo_d;
      pad_hi_q <= pad_hi_d;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[idx_q];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (cmd_i.merge) begin
      mrg_lo_q <= mrg_lo_d;
      mrg_hi_q <= mrg_hi_d;
    end
    if (cmd_i.commit) begin
      case (cmd_i.kind)
        KIND_FIT: begin
          out_index_q <= idx_wide[GIDX_W-1:0];
          out_opened_q <= 1'b0;
          out_full_q <= 1'b0;
        end
        KIND_NEW: begin
          out_index_q <= cnt_wide[GIDX_W-1:0];
          out_opened_q <= 1'b1;
          out_full_q <= 1'b0;
        end
        default: begin
          out_index_q <= '0;
          out_opened_q <= 1'b0;
          out_full_q <= 1'b1;
        end
      endcase
    end
  end

  assign status_o.empty = (count_q == '0);
  assign status_o.full = (count_q == CNT_W'(MAX_GROUPS));
  assign status_o.last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
  assign status_o.fit = &axis_ok;
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign group_index_o = out_index_q;
  assign opened_group_o = out_opened_q;
  assign table_full_o = out_full_q;

endmodule

[verif/bffg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffg_checker
// Watches the configuration port and both channels of the box first-fit
// grouper. It keeps its own cluster box, group table and register copies,
// and predicts the placement of every closed cluster. It then compares each
// result transfer field by field with the oldest predicted placement.
// ----------------------------------------------------------------------------
module bffg_checker #(
  parameter int MAX_GROUPS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bffg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bffg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                operation_i,
  input  logic signed [bffg_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [bffg_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [bffg_pkg::POS_W-1:0]   pos_z_i,
  input  logic                                last_of_cluster_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [bffg_pkg::GIDX_W-1:0]         group_index_i,
  input  logic                                opened_group_i,
  input  logic                                table_full_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import bffg_pkg::*;

  localparam longint CoordTop = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint CoordBottom = -CoordTop - 1;
  localparam int ReportLimit = 10;

  // One predicted placement, laid out like the result fields.
  typedef struct packed {
    logic [GIDX_W-1:0] group_index;
    logic              opened_group;
    logic              table_full;
  } placement_t;

  placement_t placements_due[$];

  // Shadow copy of the block's state and registers.
  longint            clu_lo[3];
  longint            clu_hi[3];
  longint            grp_lo[MAX_GROUPS][3];
  longint            grp_hi[MAX_GROUPS][3];
  int                n_groups;
  logic [MARGIN_W-1:0] margin;
  logic [LIMIT_W-1:0]  limit;
  int                fails;

  function automatic longint clamp_coord(input longint v);
    if (v > CoordTop) return CoordTop;
    if (v < CoordBottom) return CoordBottom;
    return v;
  endfunction

  function automatic void reset_cluster();
    for (int a = 0; a < 3; a++) begin
      clu_lo[a] = CoordTop;
      clu_hi[a] = CoordBottom;
    end
  endfunction

  // Folds one point into the cluster box. When the point closes the cluster,
  // places the padded box first-fit and returns 1 with the placement.
  function automatic bit fold_point(input logic signed [POS_W-1:0] x,
                                    input logic signed [POS_W-1:0] y,
                                    input logic signed [POS_W-1:0] z,
                                    input logic closes,
                                    output placement_t res);
    longint p[3];
    longint lo[3];
    longint hi[3];
    longint ml[3];
    longint mh[3];
    longint widest;
    res = '0;
    p[0] = clamp_coord(longint'(x));
    p[1] = clamp_coord(longint'(y));
    p[2] = clamp_coord(longint'(z));
    for (int a = 0; a < 3; a++) begin
      if (p[a] < clu_lo[a]) clu_lo[a] = p[a];
      if (p[a] > clu_hi[a]) clu_hi[a] = p[a];
    end
    if (!closes) return 1'b0;

    // Pad the cluster box, saturating at the coordinate range.
    for (int a = 0; a < 3; a++) begin
      lo[a] = clamp_coord(clu_lo[a] - longint'(margin));
      hi[a] = clamp_coord(clu_hi[a] + longint'(margin));
    end
    reset_cluster();

    // First fit over the stored groups.
    for (int g = 0; g < n_groups && g < MAX_GROUPS; g++) begin
      for (int a = 0; a < 3; a++) begin
        ml[a] = (lo[a] < grp_lo[g][a]) ? lo[a] : grp_lo[g][a];
        mh[a] = (hi[a] > grp_hi[g][a]) ? hi[a] : grp_hi[g][a];
      end
      widest = mh[0] - ml[0];
      for (int a = 1; a < 3; a++) begin
        if (mh[a] - ml[a] > widest) widest = mh[a] - ml[a];
      end
      if (widest <= longint'(limit)) begin
        for (int a = 0; a < 3; a++) begin
          grp_lo[g][a] = ml[a];
          grp_hi[g][a] = mh[a];
        end
        res.group_index = GIDX_W'(g);
        return 1'b1;
      end
    end

    // Nothing fit: open a group if a slot is free, otherwise drop.
    if (n_groups < MAX_GROUPS) begin
      for (int a = 0; a < 3; a++) begin
        grp_lo[n_groups][a] = lo[a];
        grp_hi[n_groups][a] = hi[a];
      end
      res.group_index = GIDX_W'(n_groups);
      res.opened_group = 1'b1;
      n_groups++;
    end else begin
      res.table_full = 1'b1;
    end
    return 1'b1;
  endfunction

  // Track registers, compare result transfers, predict input transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    placement_t got;
    bit         produced;
    if (!rst_ni) begin
      placements_due.delete();
      reset_cluster();
      n_groups = 0;
      margin = '0;
      limit = LIMIT_RESET;
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          REG_BOX_MARGIN:   margin = cfg_data_i[MARGIN_W-1:0];
          REG_EXTENT_LIMIT: limit = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        got = '{group_index: group_index_i, opened_group: opened_group_i,
                table_full: table_full_i};
        if (placements_due.size() == 0) begin
          if (fails < ReportLimit)
            $display("%0t: unexpected result: group %0d opened %0b full %0b",
                     $realtime, got.group_index, got.opened_group,
                     got.table_full);
          fails++;
        end else begin
          want = placements_due.pop_front();
          if (got.group_index !== want.group_index ||
              got.opened_group !== want.opened_group ||
              got.table_full !== want.table_full) begin
            if (fails < ReportLimit)
              $display({"%0t: placement mismatch: expected group %0d opened %0b",
                        " full %0b, got group %0d opened %0b full %0b"},
                       $realtime, want.group_index, want.opened_group,
                       want.table_full, got.group_index, got.opened_group,
                       got.table_full);
            fails++;
          end
        end
      end

      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        if (operation_i == OP_CLEAR) begin
          n_groups = 0;
          reset_cluster();
        end else begin
          produced = fold_point(pos_x_i, pos_y_i, pos_z_i, last_of_cluster_i,
                                want);
          if (produced) placements_due = {placements_due, want};
        end
      end

      fail_count_o <= fails;
      pending_o <= placements_due.size();
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the box first-fit grouper. A short directed run
// covers the extremes, clears and table overflow. Then random cluster streams
// run under several register settings, with bursty input and a patterned
// stall on the result side. A checker instance does all prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import bffg_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 64;
  localparam int HoldCycles = 400;
  localparam longint PosMax = 64'sd8388607;
  localparam longint PosMin = -64'sd8388608;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    operation_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic signed [POS_W-1:0] pos_z_i;
  logic                    last_of_cluster_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [GIDX_W-1:0]       group_index_o;
  logic                    opened_group_o;
  logic                    table_full_o;

  int          fail_count;
  int          pending;
  int          cycles;
  int          burst_left;
  logic        hold_req;
  int unsigned cur_limit;

  box_first_fit_grouper_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .last_of_cluster_i (last_of_cluster_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .group_index_o     (group_index_o),
    .opened_group_o    (opened_group_o),
    .table_full_o      (table_full_o)
  );

  bffg_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .operation_i       (operation_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .last_of_cluster_i (last_of_cluster_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .group_index_i     (group_index_o),
    .opened_group_i    (opened_group_o),
    .table_full_i      (table_full_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result-side stall pattern, with one long hold-off on request.
  initial begin
    int  mode;
    int  run;
    int  hold_left;
    bit  hold_taken;
    mode = 0;
    run = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req === 1'b1 && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 3);
          run = $urandom_range(4, 64);
        end
        run--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= run[1];
        endcase
      end
    end
  end

  // Saturate a wide value to the input coordinate range.
  function automatic logic signed [POS_W-1:0] coord(input longint v);
    if (v > PosMax) return POS_W'(PosMax);
    if (v < PosMin) return POS_W'(PosMin);
    return POS_W'(v);
  endfunction

  function automatic longint rand_coord();
    logic signed [POS_W-1:0] v;
    v = POS_W'($urandom());
    return longint'(v);
  endfunction

  function automatic longint rand_offset(input longint span);
    longint s;
    s = (span > (longint'(1) << 28)) ? (longint'(1) << 28) : span;
    if (s <= 0) return 0;
    return longint'($urandom_range(0, 32'(2 * s))) - s;
  endfunction

  // Offers one item and returns at the edge of its transfer, adding a random
  // gap at the end of each burst.
  task automatic offer(input logic op, input longint x, input longint y,
                       input longint z, input logic closes);
    int gap;
    in_valid_i <= 1'b1;
    operation_i <= op;
    pos_x_i <= coord(x);
    pos_y_i <= coord(y);
    pos_z_i <= coord(z);
    last_of_cluster_i <= closes;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops offering and waits until every predicted placement has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Drives one register write and returns at its edge, leaving the enable
  // high for the caller to drop.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned margin, input int unsigned limit);
    write_reg(REG_BOX_MARGIN, CFG_DATA_W'(margin));
    write_reg(REG_EXTENT_LIMIT, CFG_DATA_W'(limit));
    cfg_we_i <= 1'b0;
    cur_limit = limit & 32'hFFFFFF;
  endtask

  // Sends a cluster of points scattered around a center, the last one closing.
  task automatic send_cluster(input longint cx, input longint cy, input longint cz,
                              input longint spread, input int npts);
    for (int k = 0; k < npts; k++) begin
      offer(OP_POINT, cx + rand_offset(spread), cy + rand_offset(spread),
            cz + rand_offset(spread), k == npts - 1);
    end
  endtask

  // Mostly well-formed clusters around a region, plus noise and clears.
  task automatic random_phase(input int n_items);
    longint rx, ry, rz, cx, cy, cz, rspan, pspread;
    int     sent, kind, npts;
    sent = 0;
    rx = rand_coord();
    ry = rand_coord();
    rz = rand_coord();
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      npts = $urandom_range(1, 6);
      rspan = longint'(cur_limit) * 3 + 64;
      pspread = longint'(cur_limit >> $urandom_range(1, 5)) + $urandom_range(0, 8);
      if (kind < 76) begin
        send_cluster(rx + rand_offset(rspan), ry + rand_offset(rspan),
                     rz + rand_offset(rspan), pspread, npts);
        sent += npts;
      end else if (kind < 84) begin
        send_cluster(rand_coord(), rand_coord(), rand_coord(),
                     longint'($urandom_range(0, 1 << 20)), npts);
        sent += npts;
      end else if (kind < 88) begin
        // Cluster pressed against the corners of the coordinate range.
        cx = $urandom_range(0, 1) ? PosMax : PosMin;
        cy = $urandom_range(0, 1) ? PosMax : PosMin;
        cz = $urandom_range(0, 1) ? PosMax : PosMin;
        send_cluster(cx, cy, cz, pspread, npts);
        sent += npts;
      end else if (kind < 94) begin
        offer(OP_POINT, rand_coord(), rand_coord(), rand_coord(),
              logic'($urandom_range(0, 1)));
        sent++;
      end else if (kind < 97) begin
        // A cluster cut short by a clear.
        for (int k = 0; k < npts; k++) begin
          offer(OP_POINT, rx + rand_offset(rspan), ry + rand_offset(rspan),
                rz + rand_offset(rspan), 1'b0);
        end
        offer(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
              logic'($urandom_range(0, 1)));
        sent += npts + 1;
      end else begin
        offer(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
              logic'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_BOX_MARGIN;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    operation_i <= OP_POINT;
    pos_x_i <= '0;
    pos_y_i <= '0;
    pos_z_i <= '0;
    last_of_cluster_i <= 1'b0;
    hold_req <= 1'b0;
    burst_left = 0;
    cur_limit = LIMIT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values.
    offer(OP_POINT, 0, 0, 0, 1'b1);
    offer(OP_POINT, 100, -100, 50, 1'b1);
    offer(OP_POINT, PosMax, PosMax, PosMax, 1'b0);
    offer(OP_POINT, PosMin, PosMin, PosMin, 1'b1);
    offer(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'b1);
    offer(OP_POINT, 5, 5, 5, 1'b0);
    offer(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'b0);
    offer(OP_POINT, -7, 3, 9, 1'b1);
    // Far-apart clusters fill the table; the last one overflows it.
    for (int k = 0; k < 16; k++) begin
      offer(OP_POINT, 100000 + k * 40000, 0, 0, 1'b1);
    end
    drain();

    // Random part across several register settings.
    set_config(0, 0);
    random_phase(250);
    drain();

    set_config(256, 24320);
    hold_req <= 1'b1;
    random_phase(125);
    drain();
    random_phase(125);
    drain();

    set_config(8388607, 16777215);
    random_phase(250);
    drain();

    set_config($urandom_range(0, 4095), $urandom_range(1000, 100000));
    random_phase(300);
    drain();

    set_config(8388607, 0);
    random_phase(200);
    drain();

    set_config($urandom_range(0, 8388607), $urandom_range(0, 16777215));
    random_phase(300);
    drain();

    set_config(0, 24320);
    random_phase(175);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
